// ===== hdl/sfc32_pkg.sv =====
// Package for the SFC32 stream generator: state type, step constants and
// the single-step advance function. No dependencies.
package sfc32_pkg;

   localparam int WORD_W   = 32;
   localparam int STREAM_W = 8;
   localparam int SHIFT_A  = 9;
   localparam int ROT_C    = 21;
   localparam int MUL_SH   = 3;   // times 9 is (x << 3) + x

   localparam logic KIND_DRAW = 1'b0;
   localparam logic KIND_SEED = 1'b1;

   localparam logic [STREAM_W-1:0] STREAM_RESET = 8'd1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type ctr;
   } sfc_state_type;

   function automatic word_type sfc_sum(input sfc_state_type s);
      return s.a + s.b + s.ctr;
   endfunction

   function automatic sfc_state_type sfc_advance(input sfc_state_type s,
                                                 input logic [STREAM_W-1:0] step);
      sfc_state_type n;
      word_type      sum;
      sum   = sfc_sum(s);
      n.ctr = s.ctr + {{(WORD_W-STREAM_W){1'b0}}, step};
      n.a   = s.b ^ (s.b >> SHIFT_A);
      n.b   = (s.c << MUL_SH) + s.c;
      n.c   = sum + ((s.c << ROT_C) | (s.c >> (WORD_W - ROT_C)));
      return n;
   endfunction

endpackage

// ===== hdl/sfc32_out_skid.sv =====
// Result register with one skid entry for the SFC32 stream generator.
// Depends on sfc32_pkg.
module sfc32_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sfc32_pkg::word_type push_word,
   output logic                skid_full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sfc32_pkg::word_type rsp_random_word
);
   import sfc32_pkg::*;

   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff, out_word_in;
   logic     skid_valid_ff, skid_valid_in;
   word_type skid_word_ff, skid_word_in;
   logic     take;

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = push_valid;
            skid_word_in  = push_word;
         end else begin
            out_valid_in = push_valid;
            out_word_in  = push_word;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign skid_full       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_random_word = out_word_ff;

endmodule

// ===== hdl/sfc32_stream_generator.sv =====
// Top level of the SFC32 stream generator: state registers, seed sequencer
// and configuration register. Depends on sfc32_pkg and sfc32_out_skid.
//
// Usage:
//   req_ channel (valid/stall): req_kind selects a draw or a seed; a transfer
//   happens when req_valid is high and req_stall is low.
//   rsp_ channel (valid/stall): one rsp_random_word per draw, in order.
//   csr_ channel (valid/ready): writes stream_step; csr_ready is always high.
// Throughput: one draw per cycle while req_stall is low. A seed loads the
//   state, then its SEED_ROUNDS rounds run one per cycle through the single
//   step unit, with req_stall high until they finish. A seed gives no result.
// Result path: a draw's result is on rsp_ in the cycle after its transfer when no
//   earlier result is held; otherwise it waits in the skid behind that one.
// Stall: while rsp_stall holds a result, the next result goes to a one-entry skid; while the skid
//   is occupied req_stall is high. No result is lost or repeated.
// Reset: the state words clear to zero, stream_step returns to 1 and both
//   result entries empty. A draw before any seed starts from the zero state.
module sfc32_stream_generator #(
   parameter int SEED_ROUNDS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  sfc32_pkg::word_type                 req_seed_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sfc32_pkg::word_type                 rsp_random_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfc32_pkg::STREAM_W-1:0]      csr_stream_step
);
   import sfc32_pkg::*;

   localparam int RW = $clog2(SEED_ROUNDS + 1);

   sfc_state_type         state_ff, state_in;
   logic [STREAM_W-1:0]   stream_ff;
   logic [RW-1:0]         round_ff, round_in;
   logic                  seeding;
   logic                  skid_full;
   logic                  req_fire;
   logic                  draw_fire;
   logic                  seed_fire;
   sfc_state_type         seed_state;

   assign seeding   = (round_ff != '0);
   assign req_stall = seeding || skid_full;
   assign req_fire  = req_valid && !req_stall;
   assign draw_fire = req_fire && (req_kind == KIND_DRAW);
   assign seed_fire = req_fire && (req_kind == KIND_SEED);
   assign csr_ready = 1'b1;

   always_comb begin
      seed_state.a   = '0;
      seed_state.b   = '0;
      seed_state.c   = req_seed_value;
      seed_state.ctr = {{(WORD_W-STREAM_W){1'b0}}, stream_ff};
      state_in = state_ff;
      round_in = round_ff;
      if (seeding) begin
         state_in = sfc_advance(state_ff, stream_ff);
         round_in = round_ff - 1'b1;
      end else if (seed_fire) begin
         state_in = seed_state;
         round_in = RW'(SEED_ROUNDS);
      end else if (draw_fire) begin
         state_in = sfc_advance(state_ff, stream_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         round_ff  <= '0;
         stream_ff <= STREAM_RESET;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         if (csr_valid && csr_ready) begin
            stream_ff <= csr_stream_step;
         end
      end
   end

   sfc32_out_skid u_out (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (draw_fire),
      .push_word       (sfc_sum(state_ff)),
      .skid_full       (skid_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word)
   );

`ifndef NO_ASSERTIONS
   a_seed_loads_rounds : assert property (@(posedge clock) disable iff (reset)
      seed_fire |=> (round_ff == RW'(SEED_ROUNDS)))
      else $error("seed transfer did not start the round count");

   a_draw_gives_result : assert property (@(posedge clock) disable iff (reset)
      draw_fire |=> rsp_valid)
      else $error("draw transfer produced no result");

   a_skid_implies_out : assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry held while result register empty");

   a_round_counts_down : assert property (@(posedge clock) disable iff (reset)
      seeding |=> (round_ff == $past(round_ff) - 1'b1))
      else $error("seed rounds did not count down");
`endif

endmodule
